@@ rtl/dcbf_pkg.sv @@
// ============================================================================
// dcbf_pkg: shared constants for the decimating DC-blocking filter
// Widths, register indexes and filter coefficient used by all modules.
// ============================================================================
package dcbf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 24;   // holds up to MAX_DECIMATION samples
    localparam int X_W            = 28;   // group sum after a left shift of 4
    localparam int Y_W            = 32;   // unsaturated filter state
    localparam int CNT_W          = 8;
    localparam int CFG_W          = 8;    // widest configuration register
    localparam int SHIFT_W        = 5;
    localparam int COEF_W         = 17;   // signed coefficient width
    localparam int PROD_W         = Y_W + COEF_W;
    localparam int FRAC_W         = 16;   // coefficient scale 1/65536

    localparam logic [CNT_W-1:0]        MAX_DECIMATION = 8'd128;
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN    = -5'sd12;
    localparam logic signed [SHIFT_W-1:0] SHIFT_MAX    = 5'sd4;
    localparam logic signed [COEF_W-1:0]  DCB_NUM      = 17'sd65208;  // 0.995

    // register indexes of the configuration port
    localparam logic REG_DECIM_FACTOR = 1'b0;
    localparam logic REG_SHIFT_AMOUNT = 1'b1;

    localparam logic [CFG_W-1:0]         DECIM_RESET = 8'd32;
    localparam logic signed [SHIFT_W-1:0] SHIFT_RESET = -5'sd1;

endpackage

@@ rtl/dcbf_accum.sv @@
// ============================================================================
// dcbf_accum: input register, group accumulator and normalizing shift
// Sums raw samples per group and hands the shifted group sum downstream.
// ============================================================================
module dcbf_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [dcbf_pkg::SAMPLE_W-1:0]   raw_sample,
    input  logic [dcbf_pkg::CFG_W-1:0]             decim_factor,
    input  logic signed [dcbf_pkg::SHIFT_W-1:0]    shift_amount,
    output logic                                   x_valid,
    output logic signed [dcbf_pkg::X_W-1:0]        x_level,
    input  logic                                   x_ready
);

    logic                                  in_valid_reg, in_valid_next;
    logic signed [dcbf_pkg::SAMPLE_W-1:0]  in_data_reg;
    logic signed [dcbf_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [dcbf_pkg::CNT_W-1:0]            count_reg, count_next;
    logic                                  x_valid_reg, x_valid_next;
    logic signed [dcbf_pkg::X_W-1:0]       x_reg;

    logic [dcbf_pkg::CNT_W-1:0]            eff_factor;
    logic [dcbf_pkg::CNT_W-1:0]            count_inc;
    logic signed [dcbf_pkg::SUM_W-1:0]     sum_inc;
    logic                                  group_done;
    logic                                  x_free;
    logic                                  take;
    logic                                  load_in;
    logic signed [dcbf_pkg::SHIFT_W-1:0]   sh_clamp;
    logic [2:0]                            sh_left;
    logic [3:0]                            sh_right;
    logic signed [dcbf_pkg::X_W-1:0]       sum_ext;
    logic signed [dcbf_pkg::X_W-1:0]       x_calc;

    always_comb
    begin
        if (decim_factor == '0)
        begin
            eff_factor = dcbf_pkg::CNT_W'(1);
        end
        else if (decim_factor > dcbf_pkg::MAX_DECIMATION)
        begin
            eff_factor = dcbf_pkg::MAX_DECIMATION;
        end
        else
        begin
            eff_factor = decim_factor;
        end
    end

    always_comb
    begin
        if (shift_amount < dcbf_pkg::SHIFT_MIN)
        begin
            sh_clamp = dcbf_pkg::SHIFT_MIN;
        end
        else if (shift_amount > dcbf_pkg::SHIFT_MAX)
        begin
            sh_clamp = dcbf_pkg::SHIFT_MAX;
        end
        else
        begin
            sh_clamp = shift_amount;
        end
        sh_left  = sh_clamp[dcbf_pkg::SHIFT_W-1] ? 3'd0 : sh_clamp[2:0];
        sh_right = sh_clamp[dcbf_pkg::SHIFT_W-1] ? 4'((~sh_clamp) + 5'sd1) : 4'd0;
    end

    assign count_inc  = count_reg + dcbf_pkg::CNT_W'(1);
    assign sum_inc    = sum_reg + dcbf_pkg::SUM_W'(in_data_reg);
    assign group_done = (count_inc >= eff_factor);
    assign sum_ext    = dcbf_pkg::X_W'(sum_inc);

    // arithmetic right shift floors, matching the group normalization
    assign x_calc = sh_clamp[dcbf_pkg::SHIFT_W-1] ? (sum_ext >>> sh_right)
                                                  : (sum_ext <<< sh_left);

    assign x_free   = !x_valid_reg || x_ready;
    assign take     = in_valid_reg && (!group_done || x_free);
    assign in_stall = in_valid_reg && !take;
    assign load_in  = !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        x_valid_next  = x_valid_reg && !x_ready;
        if (load_in)
        begin
            in_valid_next = in_valid;
        end
        if (take)
        begin
            if (group_done)
            begin
                sum_next     = '0;
                count_next   = '0;
                x_valid_next = 1'b1;
            end
            else
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            x_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            x_valid_reg  <= x_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_data_reg <= raw_sample;
        end
        if (take && group_done)
        begin
            x_reg <= x_calc;
        end
    end

    assign x_valid = x_valid_reg;
    assign x_level = x_reg;

endmodule

@@ rtl/dcbf_iir.sv @@
// ============================================================================
// dcbf_iir: one-pole DC-blocking high-pass and output register
// y = x - x_prev + trunc(0.995 * y_prev), saturated to 16 bits on output.
// ============================================================================
module dcbf_iir (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   x_valid,
    input  logic signed [dcbf_pkg::X_W-1:0]        x_level,
    output logic                                   x_ready,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [dcbf_pkg::SAMPLE_W-1:0]   filtered_sample,
    output logic                                   clipped
);

    logic signed [dcbf_pkg::Y_W-1:0]       y_reg, y_next;
    logic signed [dcbf_pkg::X_W-1:0]       xprev_reg, xprev_next;
    logic                                  out_valid_reg, out_valid_next;
    logic signed [dcbf_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                                  clip_reg;

    logic signed [dcbf_pkg::PROD_W-1:0]    prod;
    logic signed [dcbf_pkg::Y_W-1:0]       q;
    logic signed [dcbf_pkg::Y_W-1:0]       y_calc;
    logic signed [dcbf_pkg::SAMPLE_W-1:0]  sat;
    logic                                  clip;
    logic                                  out_free;
    logic                                  fire;

    assign prod = dcbf_pkg::PROD_W'(y_reg) * dcbf_pkg::PROD_W'(dcbf_pkg::DCB_NUM);

    // floor shift, then step back up for a negative product with a fraction
    assign q = prod[dcbf_pkg::FRAC_W +: dcbf_pkg::Y_W]
             + dcbf_pkg::Y_W'(prod[dcbf_pkg::PROD_W-1] && (|prod[dcbf_pkg::FRAC_W-1:0]));

    assign y_calc = dcbf_pkg::Y_W'(x_level) - dcbf_pkg::Y_W'(xprev_reg) + q;

    always_comb
    begin
        if (y_calc[dcbf_pkg::Y_W-1:dcbf_pkg::SAMPLE_W-1] == '0 ||
            y_calc[dcbf_pkg::Y_W-1:dcbf_pkg::SAMPLE_W-1] == '1)
        begin
            sat  = y_calc[dcbf_pkg::SAMPLE_W-1:0];
            clip = 1'b0;
        end
        else if (y_calc[dcbf_pkg::Y_W-1])
        begin
            sat  = {1'b1, {(dcbf_pkg::SAMPLE_W-1){1'b0}}};
            clip = 1'b1;
        end
        else
        begin
            sat  = {1'b0, {(dcbf_pkg::SAMPLE_W-1){1'b1}}};
            clip = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = x_valid && out_free;
    assign x_ready  = out_free;

    always_comb
    begin
        y_next         = y_reg;
        xprev_next     = xprev_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            y_next         = y_calc;
            xprev_next     = x_level;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg         <= '0;
            xprev_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            y_reg         <= y_next;
            xprev_reg     <= xprev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_reg <= sat;
            clip_reg   <= clip;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = sample_reg;
    assign clipped         = clip_reg;

endmodule

@@ rtl/decimating_dc_blocking_filter_top.sv @@
// ============================================================================
// decimating_dc_blocking_filter_top: boxcar decimator with DC-blocking IIR
// Groups raw samples, normalizes each group sum by a signed shift and runs
// the result through a one-pole high-pass; emits one saturated sample per
// group with a clip flag.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_stall  | raw_sample
//  out     | out_valid / out_stall| filtered_sample, clipped
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One raw item accepted per cycle while in_stall is low. Three register
//  stages: input register, normalized-sum register and output register;
//  a group's result is offered once its closing item has moved through
//  the input and normalized-sum registers to the output register. The filter
//  recursion (multiply by 0.995, add) closes in the filter stage.
//  Items that do not close a group keep flowing while a result waits in
//  the output register; in_stall rises only when a closing item finds the
//  downstream stages full.
//  Reset clears group count/sum, filter history and all valid flags, and
//  sets decim_factor to 32 and shift_amount to -1.
// ============================================================================
module decimating_dc_blocking_filter_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [dcbf_pkg::CFG_W-1:0]             cfg_data,
    // raw sample channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [dcbf_pkg::SAMPLE_W-1:0]   raw_sample,
    // filtered sample channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [dcbf_pkg::SAMPLE_W-1:0]   filtered_sample,
    output logic                                   clipped
);

    logic [dcbf_pkg::CFG_W-1:0]           decim_reg, decim_next;
    logic signed [dcbf_pkg::SHIFT_W-1:0]  shift_reg, shift_next;

    logic                                 x_valid;
    logic                                 x_ready;
    logic signed [dcbf_pkg::X_W-1:0]      x_level;

    // configuration registers, written only while idle (user rule, unchecked)
    always_comb
    begin
        decim_next = decim_reg;
        shift_next = shift_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dcbf_pkg::REG_DECIM_FACTOR: decim_next = cfg_data;
                dcbf_pkg::REG_SHIFT_AMOUNT: shift_next = cfg_data[dcbf_pkg::SHIFT_W-1:0];
                default:                    decim_next = decim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg <= dcbf_pkg::DECIM_RESET;
            shift_reg <= dcbf_pkg::SHIFT_RESET;
        end
        else
        begin
            decim_reg <= decim_next;
            shift_reg <= shift_next;
        end
    end

    // group accumulation and normalizing shift
    dcbf_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_sample   (raw_sample),
        .decim_factor (decim_reg),
        .shift_amount (shift_reg),
        .x_valid      (x_valid),
        .x_level      (x_level),
        .x_ready      (x_ready)
    );

    // DC-blocking high-pass and output register
    dcbf_iir u_iir (
        .clk             (clk),
        .rst_n           (rst_n),
        .x_valid         (x_valid),
        .x_level         (x_level),
        .x_ready         (x_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_sample (filtered_sample),
        .clipped         (clipped)
    );

endmodule

@@ verif/decimating_dc_blocking_filter_top_tb.sv @@
// ============================================================================
// decimating_dc_blocking_filter_top_tb: self-checking bench for the filter
// Streams raw samples through the valid/stall channels, predicts every group
// result with a cycle-free model of the decimator and DC blocker, and compares
// each emitted sample and clip flag in order. Registers change only while idle.
// ============================================================================
module decimating_dc_blocking_filter_top_tb;

    // quiet cycles (no item moved on either side) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last result: three stages plus margin
    localparam int DRAIN_CYCLES   = 6;
    // receiver back-pressure stretch, long enough to fill the pipeline
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PCT       = 31;
    localparam longint COEF_SCALE = longint'(1) << dcbf_pkg::FRAC_W;

    typedef struct packed {
        logic signed [dcbf_pkg::SAMPLE_W-1:0] sample;
        logic                                 clip;
    } filt_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic                                 cfg_index = 1'b0;
    logic [dcbf_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [dcbf_pkg::SAMPLE_W-1:0] raw_sample = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [dcbf_pkg::SAMPLE_W-1:0] filtered_sample;
    logic                                 clipped;

    // stimulus bookkeeping
    logic signed [dcbf_pkg::SAMPLE_W-1:0] pending_samples[$];
    filt_result_t                         expected_results[$];
    int                                   pushed_items = 0;
    int                                   accepted_items = 0;
    int                                   error_count = 0;
    int                                   quiet_cycles = 0;
    bit                                   in_took = 1'b0;
    bit                                   send_idle_en = 1'b1;
    bit                                   recv_idle_en = 1'b1;
    bit                                   hold_req = 1'b0;
    int                                   hold_left = 0;

    // shadow of the configuration registers (reset values of the block)
    logic [dcbf_pkg::CFG_W-1:0]           decim_cfg = dcbf_pkg::DECIM_RESET;
    logic signed [dcbf_pkg::SHIFT_W-1:0]  shift_cfg = dcbf_pkg::SHIFT_RESET;

    // predictor state: running group and filter history
    int                                   grp_sum = 0;
    int                                   grp_count = 0;
    int                                   prev_level = 0;
    int                                   prev_filter = 0;

    decimating_dc_blocking_filter_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_sample      (raw_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_sample (filtered_sample),
        .clipped         (clipped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Adds one sample to the current group; when the group closes, normalizes
    // the sum and runs the one-pole high-pass. Returns 1 when a result is due.
    function automatic bit decimate_and_filter(
        input  logic signed [dcbf_pkg::SAMPLE_W-1:0] s,
        output filt_result_t                         res);
        int     eff_factor;
        int     eff_shift;
        longint level;
        longint decayed;
        longint y_full;
        int     y_wrap;
        res = '0;
        // factor 0 behaves as 1, anything past the maximum is clamped
        if (decim_cfg == 0)
            eff_factor = 1;
        else if (decim_cfg > dcbf_pkg::MAX_DECIMATION)
            eff_factor = dcbf_pkg::MAX_DECIMATION;
        else
            eff_factor = decim_cfg;
        grp_sum   = grp_sum + s;
        grp_count = (grp_count + 1) & 8'hFF;
        // a factor lowered mid-group closes the group on the next sample
        if (grp_count < eff_factor)
            return 1'b0;

        eff_shift = shift_cfg;
        if (eff_shift < dcbf_pkg::SHIFT_MIN)
            eff_shift = dcbf_pkg::SHIFT_MIN;
        if (eff_shift > dcbf_pkg::SHIFT_MAX)
            eff_shift = dcbf_pkg::SHIFT_MAX;

        level = grp_sum;
        if (eff_shift > 0)
            level = level <<< eff_shift;
        else if (eff_shift < 0)
            level = level >>> (-eff_shift);

        // 0.995 * y_prev, truncated toward zero by integer division
        decayed = (longint'(prev_filter) * longint'(dcbf_pkg::DCB_NUM)) / COEF_SCALE;
        y_full  = level - longint'(prev_level) + decayed;
        y_wrap  = y_full[31:0];   // history wraps at 32 bits

        if (y_wrap > 32767)
        begin
            res.sample = 16'sh7FFF;
            res.clip   = 1'b1;
        end
        else if (y_wrap < -32768)
        begin
            res.sample = 16'sh8000;
            res.clip   = 1'b1;
        end
        else
        begin
            res.sample = y_wrap[15:0];
            res.clip   = 1'b0;
        end

        prev_filter = y_wrap;
        prev_level  = level[31:0];
        grp_sum     = 0;
        grp_count   = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: holds an item until it is taken; may idle between items.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_samples.size() > 0 &&
                !(send_idle_en && $urandom_range(99) < IDLE_PCT))
            begin
                in_valid   <= 1'b1;
                raw_sample <= pending_samples.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off on request so the block
    // backs up and has to stall its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= recv_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted sample, checks every accepted result,
    // and watches for a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        filt_result_t predicted;
        filt_result_t oldest;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                accepted_items++;
                if (decimate_and_filter(raw_sample, predicted))
                    expected_results.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got sample %0d clip %0b",
                             $time, filtered_sample, clipped);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (filtered_sample !== oldest.sample)
                    begin
                        error_count++;
                        $display("%0t: filtered_sample mismatch: expected %0d, got %0d",
                                 $time, oldest.sample, filtered_sample);
                    end
                    if (clipped !== oldest.clip)
                    begin
                        error_count++;
                        $display("%0t: clipped mismatch: expected %0b, got %0b",
                                 $time, oldest.clip, clipped);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic signed [dcbf_pkg::SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        pushed_items++;
    endtask

    // Block is idle once every sample is taken, every result has arrived and
    // the last non-closing sample has left the input stage.
    task automatic wait_idle();
        while (accepted_items != pushed_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [dcbf_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == dcbf_pkg::REG_DECIM_FACTOR)
            decim_cfg = val;
        else
            shift_cfg = val[dcbf_pkg::SHIFT_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed corners, a full-scale stretch with the largest group
    // sums, then random phases with random settings.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                                   g;
        int                                   k;
        int                                   p;
        int                                   n;
        int                                   pick;
        int                                   fac;
        logic signed [dcbf_pkg::SAMPLE_W-1:0] s;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every sample its own group, no scaling: field extremes and patterns
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd1);
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'd0);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'shFFFF);
        push_sample(16'sh0001);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        wait_idle();

        // left shift by 4: saturates high then low
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'd4);
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        wait_idle();

        // factor 0 acts as 1; shift -16 clamps to -12
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd0);
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'(-16));
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        wait_idle();

        // shift 15 clamps to 4, groups of three
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd3);
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'd15);
        push_sample(16'sh1234);
        push_sample(16'shF00D);
        push_sample(16'sh7FFF);
        wait_idle();

        // factor lowered mid-group: three of four taken, then factor 2
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd4);
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'(-1));
        push_sample(16'sh4000);
        push_sample(16'shC001);
        push_sample(16'sh0100);
        wait_idle();
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd2);
        push_sample(16'sh7FFF);
        wait_idle();

        // Factor above the maximum (acts as 128), shift 4, one full-scale
        // group of each sign: the largest normalized sums, both clipping.
        // No idling on either side in this stretch.
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'd200);
        write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'd4);
        for (g = 0; g < 2; g++)
            for (k = 0; k < 128; k++)
                push_sample((g % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        wait_idle();

        // random phases; the first one runs the long receiver hold-off
        for (p = 0; p < 8; p++)
        begin
            pick = $urandom_range(99);
            if (p == 0)
                fac = 1;
            else if (pick < 55)
                fac = $urandom_range(4, 1);
            else if (pick < 80)
                fac = $urandom_range(16, 5);
            else if (pick < 90)
                fac = $urandom_range(40, 17);
            else if (pick < 95)
                fac = 0;
            else
                fac = $urandom_range(255, 128);
            write_reg(dcbf_pkg::REG_DECIM_FACTOR, 8'(fac));
            write_reg(dcbf_pkg::REG_SHIFT_AMOUNT, 8'($urandom_range(31)));

            send_idle_en = (p != 0);
            recv_idle_en = ($urandom_range(3) != 0);
            if (p == 0)
                hold_req = 1'b1;

            n = $urandom_range(40, 30);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    case ($urandom_range(3))
                        0:       s = 16'sh7FFF;
                        1:       s = 16'sh8000;
                        2:       s = 16'sh0000;
                        default: s = 16'shFFFF;
                    endcase
                end
                else
                begin
                    s = 16'($urandom);
                end
                push_sample(s);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dcbf_pkg.sv
rtl/dcbf_accum.sv
rtl/dcbf_iir.sv
rtl/decimating_dc_blocking_filter_top.sv
verif/decimating_dc_blocking_filter_top_tb.sv
